FILE: hdl/ratnorm_pkg.sv
// ----------------------------------------------------------------------------
// ratnorm_pkg - shared types and codes for the rational normalizer
// Status codes of a result and the busy/done status word that the
// iterative units report to the sequencer.
// ----------------------------------------------------------------------------
package ratnorm_pkg;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DEN_ZERO = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  // status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } ratnorm_stat_t;

endpackage

FILE: hdl/rational_normalize.sv
// ----------------------------------------------------------------------------
// rational_normalize - reduces a signed fraction to lowest terms
// Sign handling and range checks, then a binary gcd and two bit-serial
// divisions of the scaled magnitudes by the odd gcd part.
// ----------------------------------------------------------------------------
//  channel  | ports                             | handshake
//  ---------+-----------------------------------+---------------------------
//  input    | num_in, den_in                    | start & !busy
//  result   | num_out, den_out, status          | done, one cycle, no stall
//
//  An ordinary transaction holds busy through the gcd steps and the step
//  that sees the end, then through two divisions on the one shared
//  divider and the three hand-overs; the result strobe follows in the
//  next cycle. A zero denominator or an out-of-range operand gives its
//  result in the next cycle.
//  Reset is synchronous and returns the sequencer to idle with no result.
//  The result strobe lasts one cycle; the receiver cannot stall it, and a
//  new transaction may start in the cycle in which a result is shown.
// ----------------------------------------------------------------------------
module rational_normalize #(
  parameter int WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [WIDTH-1:0] num_in,
  input  logic signed [WIDTH-1:0] den_in,
  output logic                    done,
  output logic signed [WIDTH-1:0] num_out,
  output logic [WIDTH-2:0]        den_out,
  output logic [1:0]              status
);
  import ratnorm_pkg::*;

  localparam int MAGW = WIDTH - 1;
  localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_GCD  = 2'd1;
  localparam logic [1:0] S_DIVN = 2'd2;
  localparam logic [1:0] S_DIVD = 2'd3;

  logic [1:0]      state;
  logic            accept;
  logic            den_zero;
  logic            out_range;
  logic [WIDTH-1:0] num_neg, den_neg;
  logic [MAGW-1:0] num_mag, den_mag;
  logic            neg;
  logic [MAGW-1:0] qn;
  logic [WIDTH-1:0] num_signed;

  ratnorm_stat_t   gcd_stat, div_stat;
  logic [MAGW-1:0] g_odd, n_scaled, d_scaled;
  logic            div_start;
  logic [MAGW-1:0] div_dividend;
  logic [MAGW-1:0] quotient;

  // input checks and magnitudes
  assign accept    = start && !busy;
  assign den_zero  = (den_in == '0);
  assign out_range = (num_in == MOST_NEG) || (den_in == MOST_NEG);
  assign num_neg   = ~num_in + 1'b1;
  assign den_neg   = ~den_in + 1'b1;
  assign num_mag   = num_in[WIDTH-1] ? num_neg[MAGW-1:0] : num_in[MAGW-1:0];
  assign den_mag   = den_in[WIDTH-1] ? den_neg[MAGW-1:0] : den_in[MAGW-1:0];

  ratnorm_gcd #(.MAGW(MAGW)) u_gcd (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && !den_zero && !out_range),
    .a_in     (num_mag),
    .b_in     (den_mag),
    .stat     (gcd_stat),
    .g_odd    (g_odd),
    .a_scaled (n_scaled),
    .b_scaled (d_scaled)
  );

  // shared divider: numerator first, then denominator
  assign div_start    = ((state == S_GCD) && gcd_stat.done) ||
                        ((state == S_DIVN) && div_stat.done);
  assign div_dividend = (state == S_GCD) ? n_scaled : d_scaled;

  ratnorm_div #(.MAGW(MAGW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (g_odd),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // sign of the reduced numerator
  assign num_signed = neg ? (~{1'b0, qn} + 1'b1) : {1'b0, qn};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (den_zero || out_range) begin
              done <= 1'b1;
            end else begin
              state <= S_GCD;
            end
          end
        end
        S_GCD: begin
          if (gcd_stat.done) begin
            state <= S_DIVN;
          end
        end
        S_DIVN: begin
          if (div_stat.done) begin
            state <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (div_stat.done) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= num_in[WIDTH-1] ^ den_in[WIDTH-1];
      if (den_zero) begin
        num_out <= '0;
        den_out <= '0;
        status  <= ST_DEN_ZERO;
      end else if (out_range) begin
        num_out <= '0;
        den_out <= '0;
        status  <= ST_RANGE;
      end
    end
    if ((state == S_DIVN) && div_stat.done) begin
      qn <= quotient;
    end
    if ((state == S_DIVD) && div_stat.done) begin
      num_out <= num_signed;
      den_out <= quotient;
      status  <= ST_OK;
    end
  end

  assign busy = (state != S_IDLE);

`ifndef NO_ASSERTIONS
  // the gcd unit only runs while the sequencer waits for it
  a_gcd_in_state: assert property (@(posedge clk) disable iff (rst)
    gcd_stat.busy |-> (state == S_GCD))
    else $error("gcd unit busy outside gcd phase");

  // the divider only runs in the two division phases
  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> ((state == S_DIVN) || (state == S_DIVD)))
    else $error("divider busy outside division phases");

  // an accepted transaction is either in work or answered at once
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted transaction dropped");

  // a good result always has a positive denominator
  a_den_positive: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_OK)) |-> (den_out != '0))
    else $error("zero denominator with ok status");
`endif

endmodule

FILE: hdl/ratnorm_gcd.sv
// ----------------------------------------------------------------------------
// ratnorm_gcd - iterative binary gcd, one reduction step per cycle
// Reduces two magnitudes to their odd gcd part and shifts copies of the
// operands right by the common power of two, so that the copies divided by
// the odd part are the reduced values.
// ----------------------------------------------------------------------------
module ratnorm_gcd #(
  parameter int MAGW = 31
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [MAGW-1:0]             a_in,
  input  logic [MAGW-1:0]             b_in,
  output ratnorm_pkg::ratnorm_stat_t  stat,
  output logic [MAGW-1:0]             g_odd,
  output logic [MAGW-1:0]             a_scaled,
  output logic [MAGW-1:0]             b_scaled
);
  import ratnorm_pkg::*;

  logic [MAGW-1:0] a, b, a_next, b_next;
  logic [MAGW-1:0] sa, sb, sa_next, sb_next;
  logic [MAGW-1:0] a_minus_b, b_minus_a;
  logic            b_gt_a;
  logic            finished;
  logic            busy;
  logic            done;

  // one subtract pair, the borrow picks the larger operand
  assign {b_gt_a, a_minus_b} = {1'b0, a} - {1'b0, b};
  assign b_minus_a           = b - a;
  assign finished            = (a == '0) || (b == '0);

  // reduction step
  always_comb begin
    a_next  = a;
    b_next  = b;
    sa_next = sa;
    sb_next = sb;
    if (!a[0] && !b[0]) begin
      a_next  = a >> 1;
      b_next  = b >> 1;
      sa_next = sa >> 1;
      sb_next = sb >> 1;
    end else if (!a[0]) begin
      a_next = a >> 1;
    end else if (!b[0]) begin
      b_next = b >> 1;
    end else if (!b_gt_a) begin
      a_next = a_minus_b >> 1;
    end else begin
      b_next = b_minus_a >> 1;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
      end else if (busy && finished) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      a  <= a_in;
      b  <= b_in;
      sa <= a_in;
      sb <= b_in;
    end else if (busy && !finished) begin
      a  <= a_next;
      b  <= b_next;
      sa <= sa_next;
      sb <= sb_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign g_odd     = a | b;
  assign a_scaled  = sa;
  assign b_scaled  = sb;

endmodule

FILE: hdl/ratnorm_div.sv
// ----------------------------------------------------------------------------
// ratnorm_div - bit-serial restoring divider
// The dividend shifts out of a shift register one bit per cycle while the
// quotient bits shift in behind it; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ratnorm_div #(
  parameter int MAGW = 31
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [MAGW-1:0]             dividend,
  input  logic [MAGW-1:0]             divisor,
  output ratnorm_pkg::ratnorm_stat_t  stat,
  output logic [MAGW-1:0]             quotient
);
  import ratnorm_pkg::*;

  localparam int CW = $clog2(MAGW);
  localparam logic [CW-1:0] LAST_BIT = CW'(MAGW - 1);

  logic [MAGW-1:0] rem;
  logic [MAGW-1:0] shreg;
  logic [MAGW-1:0] dsr;
  logic [CW-1:0]   cnt;
  logic [MAGW:0]   partial;
  logic [MAGW+1:0] trial;
  logic            borrow;
  logic            busy;
  logic            done;

  // trial subtraction of the divisor from the shifted remainder
  assign partial = {rem, shreg[MAGW-1]};
  assign trial   = {1'b0, partial} - {2'b00, dsr};
  assign borrow  = trial[MAGW+1];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= LAST_BIT;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem   <= '0;
      shreg <= dividend;
      dsr   <= divisor;
    end else if (busy) begin
      rem   <= borrow ? partial[MAGW-1:0] : trial[MAGW-1:0];
      shreg <= {shreg[MAGW-2:0], ~borrow};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = shreg;

endmodule
